/* design/bte_pkg.sv */
// Shared constants and types for the battery time-to-empty estimator.
`default_nettype none
package bte_pkg;

  // Window of stored power samples.
  localparam int WINDOW_DEPTH = 10;
  localparam int SAMPLE_W     = 16;
  localparam int ENERGY_W     = 20;
  localparam int MEAN_W       = 16;
  localparam int MIN_W        = 26;
  localparam int MINUTES_PER_HOUR = 60;

  // Derived widths for the window bookkeeping.
  localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
  localparam int SLOT_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int TOTAL_W = SAMPLE_W + CNT_W;

  // Shared serial divider widths.
  localparam int DIV_W  = (TOTAL_W > MIN_W) ? TOTAL_W : MIN_W;
  localparam int DSR_W  = (MEAN_W > CNT_W) ? MEAN_W : CNT_W;
  localparam int STEP_W = $clog2(DIV_W);

  // Queue between the front and the back.
  localparam int FIFO_DEPTH = 2;
  localparam int FPTR_W     = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  // One job handed from the front to the back.
  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic [CNT_W-1:0]   count;
    logic [MIN_W-1:0]   energy60;
  } bte_job_t;

endpackage
`default_nettype wire

/* design/battery_time_to_empty_unit.sv */
// Top level of the battery time-to-empty estimator.
// Each word goes through the shared one-bit-per-cycle divider: 26 steps for the mean
// and, when the mean is nonzero, 26 for the minutes; the back takes a job once idle.
// A two-entry queue lets the front accept words while the back divides or holds a result.
// Reset (asynchronous, active low) empties the window and the queue and idles the back.
`default_nettype none
module battery_time_to_empty_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [bte_pkg::SAMPLE_W-1:0] power_sample_i,
  input  wire logic [bte_pkg::ENERGY_W-1:0] energy_left_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [bte_pkg::MEAN_W-1:0]        average_power_o,
  output logic [bte_pkg::MIN_W-1:0]         minutes_remaining_o
);

  logic              push;
  logic              full;
  logic              pop;
  logic              job_valid;
  bte_pkg::bte_job_t job_in;
  bte_pkg::bte_job_t job_out;

  bte_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .power_sample_i (power_sample_i),
    .energy_left_i  (energy_left_i),
    .push_o         (push),
    .job_o          (job_in),
    .full_i         (full)
  );

  bte_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .rdata_o (job_out)
  );

  bte_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .job_valid_i         (job_valid),
    .job_i               (job_out),
    .pop_o               (pop),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .average_power_o     (average_power_o),
    .minutes_remaining_o (minutes_remaining_o)
  );

endmodule
`default_nettype wire

/* design/bte_front.sv */
// Front end: accepts sample words and updates the sliding window and its running total.
`default_nettype none
module bte_front (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [bte_pkg::SAMPLE_W-1:0]    power_sample_i,
  input  wire logic [bte_pkg::ENERGY_W-1:0]    energy_left_i,
  output logic                                 push_o,
  output bte_pkg::bte_job_t                    job_o,
  input  wire logic                            full_i
);

  logic [bte_pkg::SAMPLE_W-1:0] window_q [bte_pkg::WINDOW_DEPTH];
  logic [bte_pkg::SLOT_W-1:0]   slot_q, slot_d;
  logic [bte_pkg::CNT_W-1:0]    count_q, count_d;
  logic [bte_pkg::TOTAL_W-1:0]  total_q, total_d;
  logic                         win_full;
  logic [bte_pkg::TOTAL_W-1:0]  oldest;
  logic [bte_pkg::MIN_W-1:0]    energy_ext;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && in_ready_o;

  // Window bookkeeping for the incoming word.
  always_comb begin
    win_full = (count_q == bte_pkg::CNT_W'(bte_pkg::WINDOW_DEPTH));
    oldest   = win_full ? bte_pkg::TOTAL_W'(window_q[slot_q]) : '0;
    total_d  = total_q - oldest + bte_pkg::TOTAL_W'(power_sample_i);
    count_d  = win_full ? count_q : count_q + 1'b1;
    if (slot_q == bte_pkg::SLOT_W'(bte_pkg::WINDOW_DEPTH - 1)) begin
      slot_d = '0;
    end else begin
      slot_d = slot_q + 1'b1;
    end
  end

  // Energy times sixty as a shift-and-subtract.
  assign energy_ext = bte_pkg::MIN_W'(energy_left_i);
  always_comb begin
    job_o.total    = total_d;
    job_o.count    = count_d;
    job_o.energy60 = (energy_ext << 6) - (energy_ext << 2);
  end

  // Control state of the window.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      count_q <= '0;
      total_q <= '0;
    end else if (push_o) begin
      slot_q  <= slot_d;
      count_q <= count_d;
      total_q <= total_d;
    end
  end

  // Sample storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_o) begin
      window_q[slot_q] <= power_sample_i;
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= bte_pkg::CNT_W'(bte_pkg::WINDOW_DEPTH))
    else $error("held count above window depth");
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q < bte_pkg::SLOT_W'(bte_pkg::WINDOW_DEPTH) || bte_pkg::WINDOW_DEPTH == 1)
    else $error("write slot out of range");
`endif

endmodule
`default_nettype wire

/* design/bte_fifo.sv */
// Short job queue between the front end and the divider back end.
`default_nettype none
module bte_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire bte_pkg::bte_job_t wdata_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   valid_o,
  output bte_pkg::bte_job_t      rdata_o
);

  bte_pkg::bte_job_t             mem_q [bte_pkg::FIFO_DEPTH];
  logic [bte_pkg::FPTR_W-1:0]    wptr_q, rptr_q;
  logic [bte_pkg::FCNT_W-1:0]    cnt_q;

  assign full_o  = (cnt_q == bte_pkg::FCNT_W'(bte_pkg::FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue read while empty");
`endif

endmodule
`default_nettype wire

/* design/bte_back.sv */
// Back end: shared restoring divider for the mean and the minutes, plus the result register.
`default_nettype none
module bte_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         job_valid_i,
  input  wire bte_pkg::bte_job_t            job_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [bte_pkg::MEAN_W-1:0]        average_power_o,
  output logic [bte_pkg::MIN_W-1:0]         minutes_remaining_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MEAN = 2'd1;
  localparam logic [1:0] S_MIN  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]                   state_q, state_d;
  logic [bte_pkg::STEP_W-1:0]   step_q, step_d;
  logic [bte_pkg::DIV_W-1:0]    quo_q, quo_d;
  logic [bte_pkg::DSR_W-1:0]    rem_q, rem_d;
  logic [bte_pkg::DSR_W-1:0]    dsr_q, dsr_d;
  logic [bte_pkg::MIN_W-1:0]    energy_q, energy_d;
  logic [bte_pkg::MEAN_W-1:0]   mean_q, mean_d;
  logic [bte_pkg::MIN_W-1:0]    minutes_q, minutes_d;

  logic [bte_pkg::DSR_W:0]      rem_sh, rem_sub;
  logic                         ge;
  logic [bte_pkg::DIV_W-1:0]    quo_nx;
  logic                         last_step;

  // One quotient bit per cycle.
  always_comb begin
    rem_sh    = {rem_q, quo_q[bte_pkg::DIV_W-1]};
    rem_sub   = rem_sh - {1'b0, dsr_q};
    ge        = (rem_sh >= {1'b0, dsr_q});
    quo_nx    = {quo_q[bte_pkg::DIV_W-2:0], ge};
    last_step = (step_q == bte_pkg::STEP_W'(bte_pkg::DIV_W - 1));
  end

  // Sequencer for the two divisions.
  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    dsr_d     = dsr_q;
    energy_d  = energy_q;
    mean_d    = mean_q;
    minutes_d = minutes_q;
    pop_o     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          pop_o    = 1'b1;
          quo_d    = bte_pkg::DIV_W'(job_i.total);
          rem_d    = '0;
          dsr_d    = bte_pkg::DSR_W'(job_i.count);
          energy_d = job_i.energy60;
          step_d   = '0;
          state_d  = S_MEAN;
        end
      end
      S_MEAN: begin
        quo_d  = quo_nx;
        rem_d  = ge ? rem_sub[bte_pkg::DSR_W-1:0] : rem_sh[bte_pkg::DSR_W-1:0];
        step_d = step_q + 1'b1;
        if (last_step) begin
          mean_d = quo_nx[bte_pkg::MEAN_W-1:0];
          if (quo_nx[bte_pkg::MEAN_W-1:0] == '0) begin
            // A zero mean gives zero minutes without a second division.
            minutes_d = '0;
            state_d   = S_OUT;
          end else begin
            quo_d   = bte_pkg::DIV_W'(energy_q);
            rem_d   = '0;
            dsr_d   = bte_pkg::DSR_W'(quo_nx[bte_pkg::MEAN_W-1:0]);
            step_d  = '0;
            state_d = S_MIN;
          end
        end
      end
      S_MIN: begin
        quo_d  = quo_nx;
        rem_d  = ge ? rem_sub[bte_pkg::DSR_W-1:0] : rem_sh[bte_pkg::DSR_W-1:0];
        step_d = step_q + 1'b1;
        if (last_step) begin
          minutes_d = quo_nx[bte_pkg::MIN_W-1:0];
          state_d   = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    quo_q     <= quo_d;
    rem_q     <= rem_d;
    dsr_q     <= dsr_d;
    energy_q  <= energy_d;
    mean_q    <= mean_d;
    minutes_q <= minutes_d;
  end

  assign out_valid_o         = (state_q == S_OUT);
  assign average_power_o     = mean_q;
  assign minutes_remaining_o = minutes_q;

`ifndef ASSERT_OFF
  a_nonzero_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && job_valid_i) |-> job_i.count != '0)
    else $error("job with empty window");
  a_min_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MIN) |-> dsr_q != '0)
    else $error("minutes division by zero mean");
`endif

endmodule
`default_nettype wire

/* dv/tb_battery_time_to_empty_unit.sv */
// Self-checking testbench for the battery time-to-empty estimator top level.
`timescale 1ns / 1ps

module tb_battery_time_to_empty_unit;

  localparam int RANDOM_READINGS = 1950;
  localparam int DRAIN_CYCLES    = 80;
  localparam int MAX_ENERGY      = (1 << bte_pkg::ENERGY_W) - 1;
  localparam int MAX_SAMPLE      = (1 << bte_pkg::SAMPLE_W) - 1;

  // One input word and one result word.
  typedef struct packed {
    logic [bte_pkg::SAMPLE_W-1:0] power;
    logic [bte_pkg::ENERGY_W-1:0] energy;
  } reading_t;

  typedef struct packed {
    logic [bte_pkg::MEAN_W-1:0] average;
    logic [bte_pkg::MIN_W-1:0]  minutes;
  } estimate_t;

  // Shapes of the random power traces.
  typedef enum int {
    MIX_FULL,
    MIX_NEAR_ZERO,
    MIX_NEAR_MAX,
    MIX_LIGHT_LOAD
  } power_mix_e;

  logic                         clk_i;
  logic                         rst_ni              = 1'b0;
  logic                         in_valid_i          = 1'b0;
  logic                         in_ready_o;
  logic [bte_pkg::SAMPLE_W-1:0] power_sample_i      = '0;
  logic [bte_pkg::ENERGY_W-1:0] energy_left_i       = '0;
  logic                         out_valid_o;
  logic                         out_ready_i         = 1'b0;
  logic [bte_pkg::MEAN_W-1:0]   average_power_o;
  logic [bte_pkg::MIN_W-1:0]    minutes_remaining_o;

  reading_t  readings_to_send[$];
  estimate_t pending_estimates[$];

  // Our own copy of the sample window.
  logic [bte_pkg::SAMPLE_W-1:0] window_samples[bte_pkg::WINDOW_DEPTH];
  int unsigned                  window_slot  = 0;
  int unsigned                  window_held  = 0;
  int unsigned                  window_sum   = 0;

  int errors          = 0;
  int words_sent      = 0;
  int estimates_seen  = 0;
  int zero_mean_count = 0;
  int full_window_cnt = 0;
  int send_gap        = 0;
  int send_quiet      = 0;
  int stall_left      = 0;
  int recv_quiet      = 0;

  battery_time_to_empty_unit DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .power_sample_i     (power_sample_i),
    .energy_left_i      (energy_left_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .average_power_o    (average_power_o),
    .minutes_remaining_o(minutes_remaining_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int draw_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_reading(input int power, input int energy);
    reading_t r;
    r.power  = bte_pkg::SAMPLE_W'(power);
    r.energy = bte_pkg::ENERGY_W'(energy);
    readings_to_send.push_back(r);
  endtask

  // Slide the window by one sample and queue the mean and minutes that follow.
  task automatic update_window_estimate(input logic [bte_pkg::SAMPLE_W-1:0] power,
                                        input logic [bte_pkg::ENERGY_W-1:0] energy);
    estimate_t   est;
    int unsigned mean;
    int unsigned minutes;
    if (window_held == bte_pkg::WINDOW_DEPTH) begin
      window_sum -= window_samples[window_slot];
      full_window_cnt++;
    end else begin
      window_held++;
    end
    window_samples[window_slot] = power;
    window_sum += power;
    window_slot = (window_slot + 1 == bte_pkg::WINDOW_DEPTH) ? 0 : window_slot + 1;

    mean = window_sum / window_held;
    if (mean > 0) begin
      minutes = (energy * bte_pkg::MINUTES_PER_HOUR) / mean;
    end else begin
      minutes = 0;
      zero_mean_count++;
    end
    est.average = bte_pkg::MEAN_W'(mean);
    est.minutes = bte_pkg::MIN_W'(minutes);
    pending_estimates.push_back(est);
  endtask

  // Driver: presents queued readings, with random gaps between words.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        update_window_estimate(power_sample_i, energy_left_i);
        words_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (readings_to_send.size() > 0) begin
          reading_t r;
          r = readings_to_send.pop_front();
          in_valid_i     <= 1'b1;
          power_sample_i <= r.power;
          energy_left_i  <= r.energy;
          if (send_quiet > 0) begin
            send_quiet--;
            send_gap = 0;
          end else begin
            send_gap = draw_gap();
            if ($urandom_range(0, 99) == 0) send_quiet = $urandom_range(10, 40);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result word against the oldest estimate and stalls at random.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_estimates.size() == 0) begin
          $display("%0t: unexpected result average_power=%0d minutes_remaining=%0d",
                   $time, average_power_o, minutes_remaining_o);
          errors++;
        end else begin
          estimate_t want;
          want = pending_estimates.pop_front();
          estimates_seen++;
          if (average_power_o !== want.average) begin
            $display("%0t: average_power expected %0d, actual %0d",
                     $time, want.average, average_power_o);
            errors++;
          end
          if (minutes_remaining_o !== want.minutes) begin
            $display("%0t: minutes_remaining expected %0d, actual %0d",
                     $time, want.minutes, minutes_remaining_o);
            errors++;
          end
        end
      end
      if (stall_left == 0) begin
        if (recv_quiet > 0) begin
          recv_quiet--;
        end else begin
          stall_left = draw_gap();
          if ($urandom_range(0, 199) == 0) recv_quiet = $urandom_range(100, 400);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int         made;
    int         seg_len;
    int         k;
    int         pick;
    int         power;
    int         energy;
    power_mix_e mix;

    for (k = 0; k < bte_pkg::WINDOW_DEPTH; k++) window_samples[k] = '0;

    // Zero mean with a partly filled window, then a mean that truncates to zero.
    add_reading(0, MAX_ENERGY);
    add_reading(1, MAX_ENERGY);
    // Full-scale samples fill the window and wrap over the oldest entries.
    for (k = 0; k < bte_pkg::WINDOW_DEPTH; k++) begin
      add_reading(MAX_SAMPLE, (k == 3) ? 0 : (k == 4) ? 1 : MAX_ENERGY);
    end
    // Zeros push the full-scale samples out until the mean is zero again.
    for (k = 0; k < bte_pkg::WINDOW_DEPTH; k++) begin
      add_reading(0, (k % 2) ? MAX_ENERGY : 12345);
    end
    // A mean of zero with a nonzero total, then a mean of one for the longest estimate.
    add_reading(1, MAX_ENERGY);
    add_reading(10, MAX_ENERGY);

    // Random traces in segments of one load shape.
    made = 0;
    while (made < RANDOM_READINGS) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) mix = MIX_FULL;
      else if (pick < 70) mix = MIX_NEAR_ZERO;
      else if (pick < 85) mix = MIX_NEAR_MAX;
      else mix = MIX_LIGHT_LOAD;
      seg_len = $urandom_range(1, 30);
      for (k = 0; k < seg_len && made < RANDOM_READINGS; k++) begin
        unique case (mix)
          MIX_NEAR_ZERO:  power = $urandom_range(0, 1);
          MIX_NEAR_MAX:   power = $urandom_range(MAX_SAMPLE - 255, MAX_SAMPLE);
          MIX_LIGHT_LOAD: power = $urandom_range(0, 255);
          default:        power = $urandom_range(0, MAX_SAMPLE);
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 8) energy = 0;
        else if (pick < 16) energy = MAX_ENERGY;
        else energy = $urandom_range(0, MAX_ENERGY);
        add_reading(power, energy);
        made++;
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (readings_to_send.size() > 0 || in_valid_i || pending_estimates.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d readings and checked %0d estimates.", words_sent, estimates_seen);
    $display("Zero-mean estimates: %0d, words taken with a full window: %0d.",
             zero_mean_count, full_window_cnt);
    if (errors == 0) begin
      $display("PASS battery_time_to_empty_unit");
    end else begin
      $display("FAIL battery_time_to_empty_unit");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #20_000_000;
    $display("FAIL battery_time_to_empty_unit");
    $finish;
  end

endmodule

/* battery_time_to_empty_unit.f */
design/bte_pkg.sv
design/bte_front.sv
design/bte_fifo.sv
design/bte_back.sv
design/battery_time_to_empty_unit.sv
dv/tb_battery_time_to_empty_unit.sv
